FILE: sv/cpfm_pkg.sv
package cpfm_pkg;

   // Default sizing
   localparam int FRAMES_DEF          = 128;
   localparam int ENTRIES_PER_DIR_DEF = 16;
   localparam int SPACES_DEF          = 8;

   // Share counts are 4 bits and saturate
   localparam int              CNT_W   = 4;
   localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

   // Field widths of the ports
   localparam int OPCODE_W = 2;
   localparam int VPN_W    = 8;
   localparam int PID_W    = 8;
   localparam int FRAME_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_FAULT  = 2'd2,
      OP_SWITCH = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ENTRY,
      ST_FREE_CNT,
      ST_FLT_CNT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_AL_CLR,
      ST_AL_WR,
      ST_FLT_WR,
      ST_FLT_UP,
      ST_SW_OWN,
      ST_SW_FREE,
      ST_FK_DIR,
      ST_FK_RD,
      ST_FK_EV,
      ST_FK_WC,
      ST_FK_END,
      ST_RESP
   } state_type;

endpackage

FILE: sv/cow_page_frame_manager_top.sv
// Copy-on-write page frame manager with two-level page tables.
// Request channel (req_*): opcode alloc, free, fault or switch/fork, with vpn,
// is_write and pid. Response channel (rsp_*): frame and success, one word per
// request. Both channels use valid/ready; a word moves when both are high.
// One request is handled at a time: req_ready is high only while the
// sequencer is idle and the response register is empty.
// Requests walk a shared page-table RAM and a share-count RAM, one access each
// per cycle. Alloc and a copying fault scan for the lowest free frame; alloc
// also clears a new directory when one is needed. Free and a fault without
// copy need no scan. Switch searches the slots for another one owned by pid;
// failing that, a fork searches for a free slot, then copies each directory
// bit and walks every entry of a present directory. After the word is taken,
// the sequencer returns to idle before the next request is taken.
// Reset clears directory-present bits, share-count valid bits, slot owners and
// the active slot, leaving only slot 0 used; no clearing pass is needed, and
// requests are taken in the first cycle after reset. A stalled receiver holds
// the response register; the block takes no new request until the word is taken.
module cow_page_frame_manager_top #(
   parameter int FRAMES          = cpfm_pkg::FRAMES_DEF,
   parameter int ENTRIES_PER_DIR = cpfm_pkg::ENTRIES_PER_DIR_DEF,
   parameter int SPACES          = cpfm_pkg::SPACES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cpfm_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [cpfm_pkg::VPN_W-1:0]    req_vpn,
   input  logic                         req_is_write,
   input  logic [cpfm_pkg::PID_W-1:0]    req_pid,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cpfm_pkg::FRAME_W-1:0]  rsp_frame,
   output logic                         rsp_success
);

   localparam int SPAN = ENTRIES_PER_DIR * ENTRIES_PER_DIR;
   localparam int FW   = $clog2(FRAMES);
   localparam int IW   = $clog2(ENTRIES_PER_DIR);
   localparam int SW   = $clog2(SPACES);
   localparam int DN   = SPACES * ENTRIES_PER_DIR;
   localparam int DW   = $clog2(DN);
   localparam int PN   = SPACES * SPAN;
   localparam int PAW  = $clog2(PN);
   localparam int EW   = FW + 3;
   localparam int EV   = FW + 2;   // valid bit
   localparam int EWR  = FW + 1;   // writable bit
   localparam int EP   = FW;       // private bit
   localparam int CW   = cpfm_pkg::CNT_W;

   // Control state
   cpfm_pkg::state_type state_ff, state_in;
   cpfm_pkg::op_type    op_ff, op_in;
   logic [cpfm_pkg::VPN_W-1:0] vpn_ff, vpn_in;
   logic                       wr_ff, wr_in;
   logic [cpfm_pkg::PID_W-1:0] pid_ff, pid_in;
   logic [EW-1:0]              e_ff, e_in;
   logic [CW-1:0]              c_ff, c_in;
   logic [FW-1:0]              fidx_ff, fidx_in;
   logic [IW-1:0]              d_ff, d_in, k_ff, k_in;
   logic [SW-1:0]              s_ff, s_in, child_ff, child_in, act_ff, act_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]              rsp_frame_ff, rsp_frame_in;
   logic                       rsp_ok_ff, rsp_ok_in;

   // Small stores in flops
   logic [DN-1:0]              dir_ff;
   logic [SPACES-1:0]          used_ff;
   logic [cpfm_pkg::PID_W-1:0] owner_ff [SPACES];
   logic [FRAMES-1:0]          cnt_vld_ff;

   // Page-table RAM
   logic [EW-1:0]  pg_mem [PN];
   logic [EW-1:0]  pg_rdata_ff;
   logic [PAW-1:0] pg_raddr, pg_waddr;
   logic [EW-1:0]  pg_wdata;
   logic           pg_we;

   // Share-count RAM
   logic [CW-1:0] cnt_mem [FRAMES];
   logic [CW-1:0] cnt_rdata_ff;
   logic [FW-1:0] cnt_raddr, cnt_raddr_ff, cnt_waddr;
   logic [CW-1:0] cnt_wdata, cval;
   logic          cnt_we;

   // Flop-store write strobes
   logic          dir_we, dir_wd;
   logic [DW-1:0] dir_wa;
   logic          slot_we;

   // Derived addresses and flags
   logic [DW-1:0]  di, pd, cd;
   logic [PAW-1:0] ei, row_a, pa, ca;
   logic           vpn_ok, live, fin, fin_ok;
   logic [FW-1:0]  fin_frame;
   logic [EW-1:0]  e_rd, e_fk;
   logic [IW-1:0]  outer;

   always_comb begin
      outer  = IW'(int'(vpn_ff) / ENTRIES_PER_DIR);
      di     = DW'(int'(act_ff) * ENTRIES_PER_DIR + int'(outer));
      ei     = PAW'(int'(act_ff) * SPAN + int'(vpn_ff));
      row_a  = PAW'(int'(act_ff) * SPAN + int'(outer) * ENTRIES_PER_DIR + int'(k_ff));
      pd     = DW'(int'(act_ff) * ENTRIES_PER_DIR + int'(d_ff));
      cd     = DW'(int'(child_ff) * ENTRIES_PER_DIR + int'(d_ff));
      pa     = PAW'(int'(act_ff) * SPAN + int'(d_ff) * ENTRIES_PER_DIR + int'(k_ff));
      ca     = PAW'(int'(child_ff) * SPAN + int'(d_ff) * ENTRIES_PER_DIR + int'(k_ff));
      vpn_ok = int'(req_vpn) < SPAN;
      e_rd   = pg_rdata_ff;
      live   = dir_ff[di] && e_rd[EV];
      cval   = cnt_vld_ff[cnt_raddr_ff] ? cnt_rdata_ff : '0;
      e_fk   = e_rd;
      if (e_rd[EWR] || e_rd[EP]) begin
         e_fk[EWR] = 1'b0;
         e_fk[EP]  = 1'b1;
      end
   end

   // Sequencer: next state, RAM ports and store strobes
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      vpn_in    = vpn_ff;
      wr_in     = wr_ff;
      pid_in    = pid_ff;
      e_in      = e_ff;
      c_in      = c_ff;
      fidx_in   = fidx_ff;
      d_in      = d_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      child_in  = child_ff;
      act_in    = act_ff;
      pg_raddr  = ei;
      pg_we     = 1'b0;
      pg_waddr  = ei;
      pg_wdata  = '0;
      cnt_raddr = fidx_ff;
      cnt_we    = 1'b0;
      cnt_waddr = fidx_ff;
      cnt_wdata = '0;
      dir_we    = 1'b0;
      dir_wa    = di;
      dir_wd    = 1'b1;
      slot_we   = 1'b0;
      fin       = 1'b0;
      fin_ok    = 1'b0;
      fin_frame = '0;

      unique case (state_ff)
         cpfm_pkg::ST_IDLE: begin
            pg_raddr = PAW'(int'(act_ff) * SPAN + int'(req_vpn));
            if (req_valid && !rsp_valid_ff) begin
               op_in  = cpfm_pkg::op_type'(req_opcode);
               vpn_in = req_vpn;
               wr_in  = req_is_write;
               pid_in = req_pid;
               s_in   = '0;
               if (cpfm_pkg::op_type'(req_opcode) == cpfm_pkg::OP_SWITCH) begin
                  state_in = cpfm_pkg::ST_SW_OWN;
               end else if (vpn_ok) begin
                  state_in = cpfm_pkg::ST_ENTRY;
               end else begin
                  fin      = 1'b1;
                  state_in = cpfm_pkg::ST_RESP;
               end
            end
         end

         cpfm_pkg::ST_ENTRY: begin
            e_in      = e_rd;
            fidx_in   = '0;
            cnt_raddr = e_rd[FW-1:0];
            case (op_ff)
               cpfm_pkg::OP_ALLOC: state_in = cpfm_pkg::ST_SCAN_RD;
               cpfm_pkg::OP_FREE: begin
                  if (live) begin
                     pg_we    = 1'b1;
                     state_in = cpfm_pkg::ST_FREE_CNT;
                  end else begin
                     fin      = 1'b1;
                     state_in = cpfm_pkg::ST_RESP;
                  end
               end
               default: begin
                  if (live && wr_ff && !e_rd[EWR] && e_rd[EP]) begin
                     state_in = cpfm_pkg::ST_FLT_CNT;
                  end else begin
                     fin      = 1'b1;
                     state_in = cpfm_pkg::ST_RESP;
                  end
               end
            endcase
         end

         // Decrement the freed frame's count, stopping at zero
         cpfm_pkg::ST_FREE_CNT: begin
            cnt_waddr = e_ff[FW-1:0];
            cnt_wdata = cval - CW'(1);
            cnt_we    = cval != '0;
            fin       = 1'b1;
            fin_ok    = 1'b1;
            state_in  = cpfm_pkg::ST_RESP;
         end

         cpfm_pkg::ST_FLT_CNT: begin
            c_in = cval;
            if (cval == CW'(1)) begin
               pg_we         = 1'b1;
               pg_wdata      = e_ff;
               pg_wdata[EWR] = 1'b1;
               fin           = 1'b1;
               fin_ok        = 1'b1;
               fin_frame     = e_ff[FW-1:0];
               state_in      = cpfm_pkg::ST_RESP;
            end else if (cval >= CW'(2)) begin
               state_in = cpfm_pkg::ST_SCAN_RD;
            end else begin
               fin      = 1'b1;
               state_in = cpfm_pkg::ST_RESP;
            end
         end

         // Search for the lowest frame with a zero count
         cpfm_pkg::ST_SCAN_RD: state_in = cpfm_pkg::ST_SCAN_CHK;

         cpfm_pkg::ST_SCAN_CHK: begin
            k_in = '0;
            if (cval == '0) begin
               if (op_ff == cpfm_pkg::OP_FAULT) begin
                  state_in = cpfm_pkg::ST_FLT_WR;
               end else if (dir_ff[di]) begin
                  state_in = cpfm_pkg::ST_AL_WR;
               end else begin
                  state_in = cpfm_pkg::ST_AL_CLR;
               end
            end else if (fidx_ff == FW'(FRAMES - 1)) begin
               fin      = 1'b1;
               state_in = cpfm_pkg::ST_RESP;
            end else begin
               fidx_in  = fidx_ff + FW'(1);
               state_in = cpfm_pkg::ST_SCAN_RD;
            end
         end

         // Zero the new directory one entry a cycle
         cpfm_pkg::ST_AL_CLR: begin
            pg_we    = 1'b1;
            pg_waddr = row_a;
            k_in     = k_ff + IW'(1);
            if (k_ff == IW'(ENTRIES_PER_DIR - 1)) begin
               state_in = cpfm_pkg::ST_AL_WR;
            end
         end

         cpfm_pkg::ST_AL_WR: begin
            pg_we              = 1'b1;
            pg_wdata[EV]       = 1'b1;
            pg_wdata[EWR]      = wr_ff;
            pg_wdata[FW-1:0]   = fidx_ff;
            dir_we             = 1'b1;
            cnt_we             = 1'b1;
            cnt_wdata          = CW'(1);
            fin                = 1'b1;
            fin_ok             = 1'b1;
            fin_frame          = fidx_ff;
            state_in           = cpfm_pkg::ST_RESP;
         end

         // Remap the shared page to the new frame and decrement the old frame's count
         cpfm_pkg::ST_FLT_WR: begin
            cnt_we           = 1'b1;
            cnt_waddr        = e_ff[FW-1:0];
            cnt_wdata        = c_ff - CW'(1);
            pg_we            = 1'b1;
            pg_wdata[EV]     = 1'b1;
            pg_wdata[EWR]    = 1'b1;
            pg_wdata[EP]     = 1'b1;
            pg_wdata[FW-1:0] = fidx_ff;
            state_in         = cpfm_pkg::ST_FLT_UP;
         end

         cpfm_pkg::ST_FLT_UP: begin
            cnt_we    = 1'b1;
            cnt_wdata = CW'(1);
            fin       = 1'b1;
            fin_ok    = 1'b1;
            fin_frame = fidx_ff;
            state_in  = cpfm_pkg::ST_RESP;
         end

         // Look for another used slot owned by pid
         cpfm_pkg::ST_SW_OWN: begin
            if (s_ff != act_ff && used_ff[s_ff] && owner_ff[s_ff] == pid_ff) begin
               act_in   = s_ff;
               fin      = 1'b1;
               fin_ok   = 1'b1;
               state_in = cpfm_pkg::ST_RESP;
            end else if (s_ff == SW'(SPACES - 1)) begin
               s_in     = '0;
               state_in = cpfm_pkg::ST_SW_FREE;
            end else begin
               s_in = s_ff + SW'(1);
            end
         end

         // Look for a free slot to fork into
         cpfm_pkg::ST_SW_FREE: begin
            d_in = '0;
            if (!used_ff[s_ff]) begin
               child_in = s_ff;
               state_in = cpfm_pkg::ST_FK_DIR;
            end else if (s_ff == SW'(SPACES - 1)) begin
               fin      = 1'b1;
               state_in = cpfm_pkg::ST_RESP;
            end else begin
               s_in = s_ff + SW'(1);
            end
         end

         // Copy one directory bit, then walk its entries if present
         cpfm_pkg::ST_FK_DIR: begin
            dir_we = 1'b1;
            dir_wa = cd;
            dir_wd = dir_ff[pd];
            k_in   = '0;
            if (dir_ff[pd]) begin
               state_in = cpfm_pkg::ST_FK_RD;
            end else if (d_ff == IW'(ENTRIES_PER_DIR - 1)) begin
               state_in = cpfm_pkg::ST_FK_END;
            end else begin
               d_in = d_ff + IW'(1);
            end
         end

         cpfm_pkg::ST_FK_RD: begin
            pg_raddr = pa;
            state_in = cpfm_pkg::ST_FK_EV;
         end

         cpfm_pkg::ST_FK_EV: begin
            e_in      = e_fk;
            cnt_raddr = e_rd[FW-1:0];
            pg_we     = 1'b1;
            if (e_rd[EV]) begin
               pg_waddr = pa;
               pg_wdata = e_fk;
               state_in = cpfm_pkg::ST_FK_WC;
            end else begin
               pg_waddr = ca;
               k_in     = k_ff + IW'(1);
               if (k_ff != IW'(ENTRIES_PER_DIR - 1)) begin
                  state_in = cpfm_pkg::ST_FK_RD;
               end else if (d_ff == IW'(ENTRIES_PER_DIR - 1)) begin
                  state_in = cpfm_pkg::ST_FK_END;
               end else begin
                  d_in     = d_ff + IW'(1);
                  state_in = cpfm_pkg::ST_FK_DIR;
               end
            end
         end

         // Write the child entry and bump the frame's count
         cpfm_pkg::ST_FK_WC: begin
            pg_we            = 1'b1;
            pg_waddr         = ca;
            pg_wdata[EV]     = 1'b1;
            pg_wdata[EP]     = e_ff[EP];
            pg_wdata[FW-1:0] = e_ff[FW-1:0];
            cnt_waddr        = e_ff[FW-1:0];
            cnt_wdata        = cval + CW'(1);
            cnt_we           = cval != cpfm_pkg::CNT_MAX;
            k_in             = k_ff + IW'(1);
            if (k_ff != IW'(ENTRIES_PER_DIR - 1)) begin
               state_in = cpfm_pkg::ST_FK_RD;
            end else if (d_ff == IW'(ENTRIES_PER_DIR - 1)) begin
               state_in = cpfm_pkg::ST_FK_END;
            end else begin
               d_in     = d_ff + IW'(1);
               state_in = cpfm_pkg::ST_FK_DIR;
            end
         end

         cpfm_pkg::ST_FK_END: begin
            slot_we  = 1'b1;
            act_in   = child_ff;
            fin      = 1'b1;
            fin_ok   = 1'b1;
            state_in = cpfm_pkg::ST_RESP;
         end

         cpfm_pkg::ST_RESP: begin
            if (!rsp_valid_ff) begin
               state_in = cpfm_pkg::ST_IDLE;
            end
         end

         default: state_in = cpfm_pkg::ST_IDLE;
      endcase

      // Load the response register, clear it when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = fin_frame;
         rsp_ok_in    = fin_ok;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpfm_pkg::ST_IDLE;
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= '0;
         used_ff      <= SPACES'(1);
         cnt_vld_ff   <= '0;
         for (int i = 0; i < SPACES; i++) begin
            owner_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         if (dir_we) begin
            dir_ff[dir_wa] <= dir_wd;
         end
         if (slot_we) begin
            used_ff[child_ff]  <= 1'b1;
            owner_ff[child_ff] <= pid_ff;
         end
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      vpn_ff       <= vpn_in;
      wr_ff        <= wr_in;
      pid_ff       <= pid_in;
      e_ff         <= e_in;
      c_ff         <= c_in;
      fidx_ff      <= fidx_in;
      d_ff         <= d_in;
      k_ff         <= k_in;
      s_ff         <= s_in;
      child_ff     <= child_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_ok_ff    <= rsp_ok_in;
      cnt_raddr_ff <= cnt_raddr;
   end

   // Page-table RAM
   always_ff @(posedge clock) begin
      if (pg_we) begin
         pg_mem[pg_waddr] <= pg_wdata;
      end
      pg_rdata_ff <= pg_mem[pg_raddr];
   end

   // Share-count RAM
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   assign req_ready   = (state_ff == cpfm_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_frame   = cpfm_pkg::FRAME_W'(rsp_frame_ff);
   assign rsp_success = rsp_ok_ff;

endmodule
